FILE: src/pua_pkg.sv
// ----------------------------------------------------------------------------
// pua_pkg: shared constants and types for partition utilization admission
// Field widths of the request and result, the percent scale, the register
// reset value and the divider length.
// ----------------------------------------------------------------------------
package pua_pkg;

  localparam int PartW        = 3;
  localparam int BudgetW      = 32;
  localparam int PeriodW      = 32;
  localparam int SumW         = 7;
  localparam int TotalW       = 7;
  localparam int ScaleW       = 7;
  localparam int DivW         = BudgetW + ScaleW;
  localparam int DivCntW      = $clog2(DivW);
  localparam int InDataW      = 72;
  localparam int OutDataW     = 16;

  localparam int MaxEntriesDef = 64;
  localparam int PartitionsDef = 8;

  localparam logic [ScaleW-1:0] PercentScale = ScaleW'(100);
  localparam logic [SumW-1:0]   LimitReset   = SumW'(99);

  // Decision taken for one request, held until the result register is free.
  typedef struct packed {
    logic              admitted;
    logic [SumW-1:0]   psum;
    logic [TotalW-1:0] total;
  } dec_t;

endpackage

FILE: src/partition_utilization_admission_top.sv
// ----------------------------------------------------------------------------
// partition_utilization_admission_top: utilization based task admission
// Usage: a request on the s_axis channel carries a partition, a budget and a
// period. The block computes floor(budget*100/period) with a radix-2 restoring
// divider that produces one quotient bit per cycle, adds it to
// the partition's stored sum and admits the task if the sum stays within the
// limit and the task count is below MAX_ENTRIES. One result per request leaves
// on m_axis: decision, partition sum, task total and a flag that all partition
// sums are within the limit, found by a scan of the sum memory, one per cycle.
// A request rejected before the divide (zero period, full table, bad
// partition) skips the divide and goes straight to the decision and scan.
// One request is worked at a time; s_axis_tready is high only
// between requests. A finished result waits in the output register while the
// next request is taken; a stalled receiver holds the block after its divide
// and scan until the register frees.
// Reset clears all sums, the task count and sets the limit to 99. The limit
// register is written with cfg_we_i and may be changed only when idle.
// ----------------------------------------------------------------------------
module partition_utilization_admission_top #(
  parameter int MAX_ENTRIES = pua_pkg::MaxEntriesDef,
  parameter int PARTITIONS  = pua_pkg::PartitionsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pua_pkg::SumW-1:0]      cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: partition[2:0], budget[34:3], period[66:35], zero fill.
  input  logic [pua_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: admitted[0], partition_sum[7:1], task_total[14:8],
  // all_within_limit[15].
  output logic [pua_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int PW  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int SCW = $clog2(PARTITIONS + 1);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StMul    = 3'd1;
  localparam logic [2:0] StDiv    = 3'd2;
  localparam logic [2:0] StDecide = 3'd3;
  localparam logic [2:0] StScan   = 3'd4;
  localparam logic [2:0] StLast   = 3'd5;

  logic [2:0] state_q, state_d;

  logic [pua_pkg::SumW-1:0]    limit_q;
  logic [pua_pkg::PartW-1:0]   part_q;
  logic [pua_pkg::BudgetW-1:0] budget_q;
  logic [pua_pkg::PeriodW-1:0] period_q;
  logic                        go_q;
  logic                        in_range_q;

  logic [pua_pkg::DivW-1:0]    div_q;
  logic [pua_pkg::PeriodW-1:0] rem_q;
  logic [pua_pkg::DivCntW-1:0] div_cnt_q;

  logic [CW-1:0]  cnt_q;
  logic [SCW-1:0] sc_q;
  logic           scan_vld_q;
  logic           ok_q;

  pua_pkg::dec_t dec_q, dec_d;

  logic                          out_valid_q;
  logic [pua_pkg::OutDataW-1:0]  out_data_q;

  // Partition sum memory with one read and one write port.
  logic [pua_pkg::SumW-1:0] mem_q [PARTITIONS];
  logic [PARTITIONS-1:0]    vld_q;
  logic [pua_pkg::SumW-1:0] rdata_q;
  logic                     rd_en;
  logic [PW-1:0]            raddr;
  logic                     wr_en;
  logic [PW-1:0]            waddr;

  // Combinational divider step.
  logic [pua_pkg::PeriodW:0]   rem_sh;
  logic [pua_pkg::PeriodW+1:0] diff;
  logic                        ge;

  logic                      in_range;
  logic                      room;
  logic [pua_pkg::SumW-1:0]  psum_eff;
  logic [pua_pkg::SumW:0]    next_sum;
  logic                      fits;
  logic                      admit;
  logic [CW-1:0]             cnt_next;
  logic                      scan_more;
  logic                      over;
  logic                      ok_next;
  logic                      out_load;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign in_range = (32'(part_q) < PARTITIONS);
  assign room     = (32'(cnt_q) < MAX_ENTRIES);

  assign rem_sh = {rem_q, div_q[pua_pkg::DivW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, period_q};
  assign ge     = !diff[pua_pkg::PeriodW+1];

  assign psum_eff = in_range_q ? rdata_q : '0;
  assign next_sum = {1'b0, psum_eff} + {1'b0, div_q[pua_pkg::SumW-1:0]};
  assign fits     = (div_q[pua_pkg::DivW-1:pua_pkg::SumW] == '0) &&
                    (next_sum <= {1'b0, limit_q});
  assign admit    = go_q && fits;
  assign cnt_next = admit ? (cnt_q + CW'(1)) : cnt_q;

  assign scan_more = (sc_q != SCW'(PARTITIONS));
  assign over      = (rdata_q > limit_q);
  assign ok_next   = ok_q && !(scan_vld_q && over);
  assign out_load  = (state_q == StLast) && (!out_valid_q || m_axis_tready);

  assign rd_en = (state_q == StMul) || ((state_q == StScan) && scan_more);
  assign raddr = (state_q == StMul) ? PW'(part_q) : sc_q[PW-1:0];
  assign wr_en = (state_q == StDecide) && admit;
  assign waddr = PW'(part_q);

  always_comb begin
    dec_d.admitted = admit;
    dec_d.psum     = admit ? next_sum[pua_pkg::SumW-1:0] : psum_eff;
    dec_d.total    = pua_pkg::TotalW'(cnt_next);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) state_d = StMul;
      end
      StMul: begin
        state_d = (in_range && (period_q != '0) && room) ? StDiv : StDecide;
      end
      StDiv: begin
        if (div_cnt_q == pua_pkg::DivCntW'(pua_pkg::DivW - 1)) state_d = StDecide;
      end
      StDecide: begin
        state_d = StScan;
      end
      StScan: begin
        if (!scan_more) state_d = StLast;
      end
      StLast: begin
        if (out_load) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      limit_q     <= pua_pkg::LimitReset;
      cnt_q       <= '0;
      vld_q       <= '0;
      scan_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_vld_q <= (state_q == StScan) && scan_more;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (state_q == StDecide) cnt_q <= cnt_next;
      if (wr_en) vld_q[waddr] <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      part_q   <= s_axis_tdata[2:0];
      budget_q <= s_axis_tdata[34:3];
      period_q <= s_axis_tdata[66:35];
    end
    unique case (state_q)
      StMul: begin
        div_q      <= {{pua_pkg::ScaleW{1'b0}}, budget_q} *
                      {{pua_pkg::BudgetW{1'b0}}, pua_pkg::PercentScale};
        rem_q      <= '0;
        div_cnt_q  <= '0;
        in_range_q <= in_range;
        go_q       <= in_range && (period_q != '0) && room;
      end
      StDiv: begin
        // The quotient bit shifts in as the dividend bit shifts out.
        div_q     <= {div_q[pua_pkg::DivW-2:0], ge};
        rem_q     <= ge ? diff[pua_pkg::PeriodW-1:0] : rem_sh[pua_pkg::PeriodW-1:0];
        div_cnt_q <= div_cnt_q + pua_pkg::DivCntW'(1);
      end
      StDecide: begin
        dec_q <= dec_d;
        sc_q  <= '0;
        ok_q  <= 1'b1;
      end
      StScan: begin
        if (scan_more) sc_q <= sc_q + SCW'(1);
        ok_q <= ok_next;
      end
      StLast: begin
        ok_q <= ok_next;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_q <= {ok_next, dec_q.total, dec_q.psum, dec_q.admitted};
    end
  end

  // Memory ports; an entry never written reads as zero.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[waddr] <= next_sum[pua_pkg::SumW-1:0];
    if (rd_en) rdata_q <= vld_q[raddr] ? mem_q[raddr] : '0;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_ENTRIES)
    else $error("task count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (($past(state_q) == StDecide) && (cnt_q == $past(cnt_q) + CW'(1))))
    else $error("task count changed outside a decision");

  a_admit_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[7:1] <= limit_q))
    else $error("admitted sum above limit");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == StMul))
    else $error("request accepted without starting work");

  a_scan_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_vld_q |-> ((state_q == StScan) || (state_q == StLast)))
    else $error("scan data outside the scan");
`endif

endmodule

FILE: tb/sv/admission_checker.sv
// ----------------------------------------------------------------------------
// admission_checker: result prediction and comparison for admission control
// Watches the limit register writes and both stream channels, keeps its own
// copy of the per-partition utilization sums, the task count and the limit,
// predicts the verdict of every accepted request and compares each result,
// field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module admission_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pua_pkg::SumW-1:0]     cfg_wdata_i,
  input  logic                         req_valid_i,
  input  logic                         req_ready_i,
  input  logic [pua_pkg::InDataW-1:0]  req_data_i,
  input  logic                         res_valid_i,
  input  logic                         res_ready_i,
  input  logic [pua_pkg::OutDataW-1:0] res_data_i,
  output int                           mismatches_o,
  output int                           results_seen_o
);

  typedef struct packed {
    logic                       admitted;
    logic [pua_pkg::SumW-1:0]   psum;
    logic [pua_pkg::TotalW-1:0] total;
    logic                       all_ok;
  } verdict_t;

  logic [pua_pkg::SumW-1:0]   util_sum [pua_pkg::PartitionsDef];
  logic [pua_pkg::TotalW-1:0] admit_tally;
  logic [pua_pkg::SumW-1:0]   util_limit;
  verdict_t                   expected_verdicts [$];

  // Decides one request and applies it to the tracked partition state.
  function automatic verdict_t decide_admission(
    input logic [pua_pkg::PartW-1:0]   part,
    input logic [pua_pkg::BudgetW-1:0] budget,
    input logic [pua_pkg::PeriodW-1:0] period
  );
    logic [63:0] share;
    logic [63:0] grown;
    verdict_t    v;
    v = '0;
    v.psum = util_sum[part];
    if (period != '0 && admit_tally < pua_pkg::MaxEntriesDef) begin
      share = (64'(budget) * 64'(pua_pkg::PercentScale)) / 64'(period);
      grown = 64'(util_sum[part]) + share;
      if (grown <= 64'(util_limit)) begin
        util_sum[part] = grown[pua_pkg::SumW-1:0];
        admit_tally    = admit_tally + 1'b1;
        v.admitted     = 1'b1;
        v.psum         = util_sum[part];
      end
    end
    v.total  = admit_tally;
    v.all_ok = 1'b1;
    for (int p = 0; p < pua_pkg::PartitionsDef; p++) begin
      if (util_sum[p] > util_limit) v.all_ok = 1'b0;
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    verdict_t got;
    verdict_t want;
    int       bad;
    if (!rst_ni) begin
      foreach (util_sum[p]) util_sum[p] = '0;
      admit_tally = '0;
      util_limit  = pua_pkg::LimitReset;
      expected_verdicts.delete();
    end else begin
      if (cfg_we_i) util_limit = cfg_wdata_i;
      if (res_valid_i && res_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        got.admitted = res_data_i[0];
        got.psum     = res_data_i[7:1];
        got.total    = res_data_i[14:8];
        got.all_ok   = res_data_i[15];
        if (expected_verdicts.size() == 0) begin
          $error("result %h arrived with no request outstanding", res_data_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_verdicts.pop_front();
          bad  = 0;
          if (got.admitted !== want.admitted) begin
            $error("admitted: expected %0d, actual %0d", want.admitted, got.admitted);
            bad++;
          end
          if (got.psum !== want.psum) begin
            $error("partition_sum: expected %0d, actual %0d", want.psum, got.psum);
            bad++;
          end
          if (got.total !== want.total) begin
            $error("task_total: expected %0d, actual %0d", want.total, got.total);
            bad++;
          end
          if (got.all_ok !== want.all_ok) begin
            $error("all_within_limit: expected %0d, actual %0d", want.all_ok, got.all_ok);
            bad++;
          end
          mismatches_o <= mismatches_o + bad;
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_verdicts.push_back(decide_admission(req_data_i[2:0], req_data_i[34:3],
                                                     req_data_i[66:35]));
      end
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for partition utilization admission
// Drives directed requests around the limit, zero periods and huge budgets,
// then random phases under several limit settings with random idling on both
// channels in alternate phases; a final mostly zero-budget phase fills the task table.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LimitCycles = 300000;
  localparam int DrainCycles = 60;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [pua_pkg::SumW-1:0]     cfg_wdata_i;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  // partition[2:0], budget[34:3], period[66:35], zero fill.
  logic [pua_pkg::InDataW-1:0]  s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // admitted[0], partition_sum[7:1], task_total[14:8], all_within_limit[15].
  logic [pua_pkg::OutDataW-1:0] m_axis_tdata;

  int requests_sent = 0;
  int results_seen;
  int mismatches;
  int cycle_count = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  partition_utilization_admission_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  admission_checker verdict_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .mismatches_o  (mismatches),
    .results_seen_o(results_seen)
  );

  // Receiver: after each result it may hold ready low for a random stall unless steady.
  initial m_axis_tready = 1'b0;
  always @(posedge clk_i) begin : rx_pace
    int w;
    if (m_axis_tready) begin
      if (m_axis_tvalid) begin
        w = steady ? 0 : $urandom_range(0, 3);
        if (w != 0) begin
          m_axis_tready <= 1'b0;
          stall_left    <= w;
        end
      end
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic [pua_pkg::PartW-1:0]   part,
                              input logic [pua_pkg::BudgetW-1:0] budget,
                              input logic [pua_pkg::PeriodW-1:0] period);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, period, budget, part};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
  endtask

  // Mostly well-formed tasks of modest utilization; the rest zero periods,
  // raw random words and the field extremes.
  task automatic random_request();
    int                          kind;
    int                          pct;
    logic [pua_pkg::PartW-1:0]   part;
    logic [pua_pkg::BudgetW-1:0] budget;
    logic [pua_pkg::PeriodW-1:0] period;
    logic [63:0]                 scaled;
    part = pua_pkg::PartW'($urandom_range(0, 7));
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      budget = $urandom();
      period = '0;
    end else if (kind < 18) begin
      budget = $urandom();
      period = $urandom();
    end else if (kind < 24) begin
      budget = $urandom_range(0, 1) ? '1 : '0;
      period = $urandom_range(0, 1) ? '1 : 32'd1;
    end else begin
      period = $urandom_range(0, 1) ? 32'($urandom_range(1, 1000)) : ($urandom() | 32'd1);
      pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 35);
      scaled = 64'(period) * 64'(pct);
      budget = 32'(scaled / 100) + 32'($urandom_range(0, 1));
    end
    send_request(part, budget, period);
  endtask

  // Lowers valid in the step of the last acceptance, then waits out every
  // outstanding result.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [pua_pkg::SumW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : watchdog
    while (cycle_count < LimitCycles) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [pua_pkg::SumW-1:0] phase_limit [6];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Limit at its reset value of 99.
    send_request(3'd0, 32'd5, 32'd0);
    send_request(3'd0, 32'd0, 32'd1);
    send_request(3'd1, '1, '1);
    send_request(3'd2, '1, 32'd1);
    send_request(3'd7, 32'd1, 32'd100);
    send_request(3'd3, 32'd99, 32'd100);
    send_request(3'd3, 32'd1, 32'd100);
    send_request(3'd4, 32'd1, '1);
    send_request(3'd5, 32'd0, '1);
    send_request(3'd6, '1, 32'd0);
    send_request(3'd5, 32'd199, 32'd200);
    send_request(3'd4, 32'd3, 32'd7);
    drain();

    set_limit(pua_pkg::SumW'(100));
    send_request(3'd3, 32'd1, 32'd100);
    send_request(3'd6, 32'd100, 32'd100);
    drain();

    // Limit below the stored sums: nothing with a nonzero share fits.
    set_limit(pua_pkg::SumW'(0));
    send_request(3'd3, 32'd0, 32'd5);
    send_request(3'd1, 32'd0, 32'd9);
    send_request(3'd2, 32'd1, 32'd1);
    drain();

    phase_limit = '{pua_pkg::SumW'(100), pua_pkg::SumW'(63), pua_pkg::SumW'(0),
                    pua_pkg::SumW'(99), pua_pkg::SumW'($urandom_range(10, 60)),
                    pua_pkg::SumW'($urandom_range(1, 99))};
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      steady = ph[0];
      set_limit(phase_limit[ph]);
      for (int n = 0; n < 75; n++) random_request();
    end

    // Zero-budget tasks always fit under a limit of 100, so the table fills.
    drain();
    steady = 1'b0;
    set_limit(pua_pkg::SumW'(100));
    for (int n = 0; n < 70; n++) begin
      if ($urandom_range(0, 3) == 0) random_request();
      else send_request(pua_pkg::PartW'($urandom_range(0, 7)), '0, $urandom() | 32'd1);
    end
    drain();
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
